// ===== design/rvsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rvsc_pkg: shared types and constants of the RV32I subset step core.
// Opcodes, command codes, fault codes, controller states and bundles.
// ----------------------------------------------------------------------------
`default_nettype none
package rvsc_pkg;
  localparam int unsigned MemBytesDefault = 4096;

  localparam logic [1:0] CmdWrite = 2'd0;
  localparam logic [1:0] CmdSetPc = 2'd1;
  localparam logic [1:0] CmdExec  = 2'd2;

  localparam logic [1:0] FaultNone  = 2'd0;
  localparam logic [1:0] FaultFetch = 2'd1;
  localparam logic [1:0] FaultData  = 2'd2;

  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpJal    = 7'h6F;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] F7Alt    = 7'h20;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_WRITE, ST_FETCH, ST_DECODE, ST_MEMRD,
    ST_LOADWAIT, ST_STORE, ST_DONE, ST_OUT
  } state_t;

  typedef struct packed {
    logic       clr_step;
    logic       load_req;
    logic       wr_step;
    logic       fetch_step;
    logic       decode;
    logic       ld_step;
    logic       ld_wait;
    logic       st_step;
    logic       commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       wr_done;
    logic       fetch_done;
    logic       fetch_bad;
    logic       is_load;
    logic       is_store;
    logic       data_bad;
    logic       mem_done;
  } ctrl_sts_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] byte_address;
    logic [31:0] word_data;
  } req_t;

  typedef struct packed {
    logic [31:0] pc_after;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_written;
    logic [11:0] store_address;
    logic [31:0] store_value;
    logic [1:0]  fault;
  } rsp_t;
endpackage
`default_nettype wire

// ===== design/rvsc_if.sv =====
// ----------------------------------------------------------------------------
// rvsc_if: valid/ready channel carrying one payload.
// Used for the request and the result channels of the step core.
// ----------------------------------------------------------------------------
`default_nettype none
interface rvsc_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/rvsc_ram.sv =====
// ----------------------------------------------------------------------------
// rvsc_ram: generic single-port RAM with registered read.
// One write and one read of the same address per cycle; a read during a write returns the old byte.
// ----------------------------------------------------------------------------
`default_nettype none
module rvsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== design/rvsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rvsc_ctrl: controller state machine of the step core.
// Sequences memory clearing, word writes, fetch, execute and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module rvsc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [1:0]          in_cmd,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rvsc_pkg::ctrl_cmd_t      cmd_o,
  input  wire rvsc_pkg::ctrl_sts_t sts_i
);
  import rvsc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.load_req = 1'b1;
          if (in_cmd == CmdWrite) begin
            state_nxt = ST_WRITE;
          end else if (in_cmd == CmdExec) begin
            state_nxt = ST_FETCH;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_WRITE: begin
        cmd_o.wr_step = 1'b1;
        if (sts_i.wr_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_FETCH: begin
        cmd_o.fetch_step = 1'b1;
        if (sts_i.fetch_bad || sts_i.fetch_done) begin
          state_nxt = sts_i.fetch_bad ? ST_OUT : ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        state_nxt = ST_MEMRD;
      end
      ST_MEMRD: begin
        if (sts_i.data_bad) begin
          state_nxt = ST_OUT;
        end else if (sts_i.is_load) begin
          cmd_o.ld_step = 1'b1;
          if (sts_i.mem_done) begin
            state_nxt = ST_LOADWAIT;
          end
        end else if (sts_i.is_store) begin
          state_nxt = ST_STORE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_LOADWAIT: begin
        cmd_o.ld_wait = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_STORE: begin
        cmd_o.st_step = 1'b1;
        if (sts_i.mem_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd_o.commit = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== design/rvsc_dp.sv =====
// ----------------------------------------------------------------------------
// rvsc_dp: datapath of the step core.
// Register file, pc, byte memory, ALU, address checks and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module rvsc_dp #(
  parameter int unsigned MEM_BYTES = rvsc_pkg::MemBytesDefault
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rvsc_pkg::req_t      req_i,
  input  wire rvsc_pkg::ctrl_cmd_t cmd_i,
  output rvsc_pkg::ctrl_sts_t      sts_o,
  output rvsc_pkg::rsp_t           rsp_o
);
  import rvsc_pkg::*;

  localparam int unsigned AW = $clog2(MEM_BYTES);

  // The block only issues one request at a time; states are the step counter.
  req_t        req_r;
  logic [31:0] regs_r [32];
  logic [31:0] pc_r, pc_nxt;
  logic [31:0] ins_r;
  logic [31:0] b_r, ea_r, res_r, npc_r;
  logic        dw_r, isld_r, isst_r, bad_r;
  logic [AW:0] clr_cnt_r;
  logic [2:0]  cnt_r;
  logic [1:0]  byte_sel;
  logic [31:0] ldw_r;
  rsp_t        rsp_r;
  rsp_t        rsp_start;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;
  logic [31:0]   base_w, data_w;

  rvsc_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  function automatic logic in_range(input logic [31:0] ad);
    return ({1'b0, ad} + 33'd3) < 33'(MEM_BYTES);
  endfunction

  assign byte_sel = cnt_r[1:0] - 2'd1;

  // Memory port addressing: byte cnt_r of a word at base_w.
  always_comb begin
    base_w = 32'(req_r.byte_address);
    data_w = req_r.word_data;
    if (cmd_i.fetch_step) begin
      base_w = pc_r;
    end else if (cmd_i.ld_step || cmd_i.st_step) begin
      base_w = ea_r;
      data_w = b_r;
    end
    mem_we    = 1'b0;
    mem_addr  = AW'(base_w + 32'(cnt_r[1:0]));
    mem_wdata = data_w[8*cnt_r[1:0] +: 8];
    if (cmd_i.clr_step) begin
      mem_we    = 1'b1;
      mem_addr  = clr_cnt_r[AW-1:0];
      mem_wdata = '0;
    end else if ((cmd_i.wr_step && in_range(base_w)) || cmd_i.st_step) begin
      mem_we = cnt_r[2] == 1'b0;
    end
  end

  logic        fetch_ok;
  assign fetch_ok = (pc_r[1:0] == 2'b00) && in_range(pc_r);

  always_comb begin
    sts_o            = '0;
    sts_o.clr_done   = clr_cnt_r == (AW+1)'(MEM_BYTES - 1);
    sts_o.wr_done    = cnt_r == 3'd3 || !in_range(base_w);
    sts_o.fetch_bad  = !fetch_ok;
    sts_o.fetch_done = cnt_r == 3'd4;
    sts_o.is_load    = isld_r;
    sts_o.is_store   = isst_r;
    sts_o.data_bad   = bad_r;
    sts_o.mem_done   = cmd_i.ld_step ? (cnt_r == 3'd4) : (cnt_r == 3'd3);
  end

  // Decode and execute from registered instruction.
  logic [6:0]  op, f7;
  logic [2:0]  f3;
  logic [4:0]  rd, rs1, rs2, sh;
  logic [31:0] a, b, immi, imms, immb, immj, res, npc, ea;
  logic        dw, isld, isst;
  always_comb begin
    op   = ins_r[6:0];
    rd   = ins_r[11:7];
    f3   = ins_r[14:12];
    rs1  = ins_r[19:15];
    rs2  = ins_r[24:20];
    f7   = ins_r[31:25];
    sh   = ins_r[24:20];
    a    = (rs1 == 5'd0) ? 32'd0 : regs_r[rs1];
    b    = (rs2 == 5'd0) ? 32'd0 : regs_r[rs2];
    immi = {{20{ins_r[31]}}, ins_r[31:20]};
    imms = {{20{ins_r[31]}}, ins_r[31:25], ins_r[11:7]};
    immb = {{19{ins_r[31]}}, ins_r[31], ins_r[7], ins_r[30:25], ins_r[11:8], 1'b0};
    immj = {{11{ins_r[31]}}, ins_r[31], ins_r[19:12], ins_r[20], ins_r[30:21], 1'b0};
    res  = '0;
    dw   = 1'b0;
    isld = 1'b0;
    isst = 1'b0;
    ea   = a + immi;
    npc  = pc_r + 32'd4;
    case (op)
      OpImm: begin
        dw = 1'b1;
        case (f3)
          3'd0: res = a + immi;
          3'd7: res = a & immi;
          3'd6: res = a | immi;
          3'd4: res = a ^ immi;
          3'd1: res = a << sh;
          3'd5: begin
            if (f7 == 7'd0) begin
              res = a >> sh;
            end else if (f7 == F7Alt) begin
              res = 32'($signed(a) >>> sh);
            end else begin
              dw = 1'b0;
            end
          end
          default: dw = 1'b0;
        endcase
      end
      OpReg: begin
        dw = 1'b1;
        case (f3)
          3'd0: begin
            if (f7 == 7'd0) begin
              res = a + b;
            end else if (f7 == F7Alt) begin
              res = a - b;
            end else begin
              dw = 1'b0;
            end
          end
          3'd7: res = a & b;
          3'd6: res = a | b;
          3'd4: res = a ^ b;
          3'd1: res = a << b[4:0];
          3'd5: begin
            if (f7 == 7'd0) begin
              res = a >> b[4:0];
            end else if (f7 == F7Alt) begin
              res = 32'($signed(a) >>> b[4:0]);
            end else begin
              dw = 1'b0;
            end
          end
          default: dw = 1'b0;
        endcase
      end
      OpLoad: begin
        isld = f3 == 3'd2;
      end
      OpStore: begin
        isst = f3 == 3'd2;
        ea   = a + imms;
      end
      OpBranch: begin
        if ((f3 == 3'd0 && a == b) || (f3 == 3'd1 && a != b)) begin
          npc = pc_r + immb;
        end
      end
      OpJal: begin
        res = pc_r + 32'd4;
        dw  = 1'b1;
        npc = pc_r + immj;
      end
      OpJalr: begin
        res = pc_r + 32'd4;
        dw  = 1'b1;
        npc = (a + immi) & ~32'd1;
      end
      OpAuipc: begin
        res = pc_r + {ins_r[31:12], 12'd0};
        dw  = 1'b1;
      end
      OpLui: begin
        res = {ins_r[31:12], 12'd0};
        dw  = 1'b1;
      end
      default: dw = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      cnt_r     <= '0;
      pc_r      <= '0;
      isld_r    <= 1'b0;
      isst_r    <= 1'b0;
      bad_r     <= 1'b0;
      dw_r      <= 1'b0;
      for (int i = 0; i < 32; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      pc_r <= pc_nxt;
      if (cmd_i.clr_step) begin
        clr_cnt_r <= clr_cnt_r + (AW+1)'(1);
      end
      if (cmd_i.load_req || cmd_i.decode || cmd_i.commit) begin
        cnt_r <= '0;
      end else if (cmd_i.wr_step || cmd_i.fetch_step || cmd_i.ld_step || cmd_i.st_step) begin
        cnt_r <= cnt_r + 3'd1;
      end
      if (cmd_i.load_req) begin
        isld_r <= 1'b0;
        isst_r <= 1'b0;
        bad_r  <= 1'b0;
        dw_r   <= 1'b0;
      end
      if (cmd_i.decode) begin
        isld_r <= isld;
        isst_r <= isst;
        bad_r  <= (isld || isst) && !in_range(ea);
        dw_r   <= dw || isld;
      end
      if (cmd_i.commit && dw_r && ins_r[11:7] != 5'd0) begin
        regs_r[ins_r[11:7]] <= isld_r ? ldw_r : res_r;
      end
    end
  end

  always_comb begin
    pc_nxt = pc_r;
    if (cmd_i.load_req && req_i.cmd == CmdSetPc) begin
      pc_nxt = 32'(req_i.byte_address);
    end else if (cmd_i.commit) begin
      pc_nxt = npc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_req) begin
      req_r <= req_i;
    end
    if (cmd_i.fetch_step && cnt_r != 3'd0) begin
      ins_r[8*byte_sel +: 8] <= mem_rdata;
    end
    if (cmd_i.ld_step && cnt_r != 3'd0) begin
      ldw_r[8*byte_sel +: 8] <= mem_rdata;
    end
    if (cmd_i.decode) begin
      b_r   <= b;
      ea_r  <= ea;
      res_r <= res;
      npc_r <= npc;
    end
  end

  always_comb begin
    rsp_start          = '0;
    rsp_start.pc_after = (req_i.cmd == CmdSetPc) ? 32'(req_i.byte_address) : pc_r;
  end

  // Result register, started when a request is taken and filled in by the write, fault and commit steps.
  always_ff @(posedge clk) begin
    if (cmd_i.load_req) begin
      rsp_r <= rsp_start;
    end else if (cmd_i.wr_step && cnt_r == 3'd0) begin
      if (in_range(base_w)) begin
        rsp_r.mem_written   <= 1'b1;
        rsp_r.store_address <= req_r.byte_address;
        rsp_r.store_value   <= req_r.word_data;
      end else begin
        rsp_r.fault <= FaultData;
      end
    end else if (cmd_i.fetch_step && !fetch_ok) begin
      rsp_r.fault <= FaultFetch;
    end else if (bad_r && !cmd_i.decode) begin
      rsp_r.fault <= FaultData;
    end else if (cmd_i.commit) begin
      rsp_r.pc_after <= npc_r;
      if (dw_r && ins_r[11:7] != 5'd0) begin
        rsp_r.reg_written <= 1'b1;
        rsp_r.reg_index   <= ins_r[11:7];
        rsp_r.reg_value   <= isld_r ? ldw_r : res_r;
      end
      if (isst_r) begin
        rsp_r.mem_written   <= 1'b1;
        rsp_r.store_address <= ea_r[11:0];
        rsp_r.store_value   <= b_r;
      end
    end
  end

  assign rsp_o = rsp_r;
endmodule
`default_nettype wire

// ===== design/rv32i_subset_core_step_core.sv =====
// ----------------------------------------------------------------------------
// rv32i_subset_core_step_core: multicycle RV32I subset core, one step per request.
//
// The in channel takes a request: cmd 0 stores a word little-endian into the
// byte memory, cmd 1 loads the pc, cmd 2 fetches and executes one instruction.
// The out channel returns exactly one result per request: the pc afterwards,
// the register write, the store and a fault code.
// The core handles one request at a time. The byte-wide memory port moves each
// word byte by byte: a word write stores four bytes, a fetch reads four, a load
// reads four more and then waits once, a store writes four more, and an
// instruction also passes a decode, a memory dispatch and a commit step. Set pc
// goes straight to the result. The result is held in a register until
// out_ready; no new request is taken while it waits. After reset the core
// clears the byte memory one byte per cycle, with in_ready low; registers and
// pc reset to zero.
// ----------------------------------------------------------------------------
`default_nettype none
module rv32i_subset_core_step_core #(
  parameter int unsigned MEM_BYTES = rvsc_pkg::MemBytesDefault
) (
  input wire logic clk,
  input wire logic rst_n,
  rvsc_if.sink     in_ch,
  rvsc_if.source   out_ch
);
  import rvsc_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  ctrl_sts_t ctrl_sts;
  req_t      req;

  assign req = in_ch.data;

  rvsc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_cmd(req.cmd), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cmd_o(ctrl_cmd), .sts_i(ctrl_sts)
  );

  rvsc_dp #(.MEM_BYTES(MEM_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n), .req_i(req),
    .cmd_i(ctrl_cmd), .sts_o(ctrl_sts), .rsp_o(out_ch.data)
  );
endmodule
`default_nettype wire
